// ===== src/hdbn_pkg.sv =====
`default_nettype none

package hdbn_pkg;

  // Default largest HDBn order the delay line is sized for.
  localparam int MAX_ORDER_DEF = 4;

  // Width of the order register and of the saturating zero-run counter.
  localparam int ORDER_W = 3;
  localparam int ZRUN_W  = 3;

  // Order value after reset.
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;

  // Smallest order the encoder works at.
  localparam int MIN_ORDER = 2;

  // Depth of the output buffer.
  localparam int OBUF_DEPTH = 2;

  // One line symbol.
  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_POS  = 2'd1,
    SYM_NEG  = 2'd2
  } sym_t;

  // Control handed to every cell of the delay line.
  typedef struct packed {
    logic wr_en;
    sym_t wr_sym;
    logic shift;
  } cell_ctrl_t;

  // One result item.
  typedef struct packed {
    logic pos_pulse;
    logic neg_pulse;
    logic final_symbol;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/hdbn_if.sv =====
`default_nettype none

// Input channel: one message bit per item.
interface hdbn_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic end_of_message;

  modport source (output valid, output data_bit, output end_of_message, input ready);
  modport sink (input valid, input data_bit, input end_of_message, output ready);
endinterface

// Result channel: one line symbol per item.
interface hdbn_out_if;
  logic valid;
  logic ready;
  logic pos_pulse;
  logic neg_pulse;
  logic final_symbol;

  modport source (output valid, output pos_pulse, output neg_pulse, output final_symbol,
                  input ready);
  modport sink (input valid, input pos_pulse, input neg_pulse, input final_symbol,
                output ready);
endinterface

// Configuration write channel for the order register.
interface hdbn_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] zero_run_order;

  modport source (output valid, output zero_run_order, input ready);
  modport sink (input valid, input zero_run_order, output ready);
endinterface

`default_nettype wire

// ===== src/hdbn_cell.sv =====
`default_nettype none

// One slot of the symbol delay line. It can be overwritten in place and then
// shifts its updated value towards the head of the line.
module hdbn_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  hdbn_pkg::cell_ctrl_t     ctrl,
  input  hdbn_pkg::sym_t           right_upd,
  output hdbn_pkg::sym_t           upd
);

  hdbn_pkg::sym_t sym_r;
  hdbn_pkg::sym_t sym_nxt;

  // Value after this cycle's write, seen by the left neighbour.
  assign upd = ctrl.wr_en ? ctrl.wr_sym : sym_r;

  // On a shift the cell takes its right neighbour's updated value.
  assign sym_nxt = ctrl.shift ? right_upd : upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r <= hdbn_pkg::SYM_ZERO;
    end else begin
      sym_r <= sym_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/hdbn_obuf.sv =====
`default_nettype none

// Two-entry output buffer that decouples the encoder from the sink.
module hdbn_obuf (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  hdbn_pkg::out_item_t   push_item,
  output logic                  room,
  hdbn_out_if.source            out_ch
);

  localparam int PW = $clog2(hdbn_pkg::OBUF_DEPTH);
  localparam int CW = $clog2(hdbn_pkg::OBUF_DEPTH + 1);

  hdbn_pkg::out_item_t mem_r [hdbn_pkg::OBUF_DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] wptr_nxt;
  logic [PW-1:0] rptr_r;
  logic [PW-1:0] rptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          pop;
  hdbn_pkg::out_item_t head;

  assign room = (count_r < CW'(hdbn_pkg::OBUF_DEPTH));
  assign pop  = out_ch.valid && out_ch.ready;
  assign head = mem_r[rptr_r];

  assign out_ch.valid        = (count_r != '0);
  assign out_ch.pos_pulse    = head.pos_pulse;
  assign out_ch.neg_pulse    = head.neg_pulse;
  assign out_ch.final_symbol = head.final_symbol;

  // Pointer and occupancy update.
  always_comb begin
    wptr_nxt  = push ? wptr_r + PW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + PW'(1) : rptr_r;
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/hdbn_line_encoder.sv =====
`default_nettype none
// A symbol is written into the delay line in the cycle its bit is taken and leaves
// once the order of later bits have arrived; it then passes through the output buffer to out_ch.
// Throughput: one item per cycle while the output buffer has room, set by the cell chain.
// An end-of-message item, or an order lowered mid-message, holds in_ch off while the line
// drains its extra pending symbols.
// Reset: synchronous on rst_n low; line, counters and polarities clear, order becomes 3.

module hdbn_line_encoder #(
  parameter int MAX_ORDER = hdbn_pkg::MAX_ORDER_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  hdbn_in_if.sink      in_ch,
  hdbn_out_if.source   out_ch,
  hdbn_cfg_if.sink     cfg_ch
);

  localparam int D  = MAX_ORDER + 1;
  localparam int IW = $clog2(D);
  localparam int FW = $clog2(D + 1);
  localparam int ZW = hdbn_pkg::ZRUN_W;
  localparam int CW = (FW > ZW) ? FW : ZW;

  // Registers.
  logic [hdbn_pkg::ORDER_W-1:0] order_r;
  logic [hdbn_pkg::ORDER_W-1:0] order_nxt;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [FW-1:0] pend_r;
  logic [FW-1:0] pend_nxt;
  logic          drain_r;
  logic          drain_nxt;
  logic [ZW-1:0] zrun_r;
  logic [ZW-1:0] zrun_nxt;
  logic          lmp_r;
  logic          lmp_nxt;
  logic          lvp_r;
  logic          lvp_nxt;

  // Combinational signals.
  logic [CW-1:0] order_raw;
  logic [CW-1:0] ord;
  logic [CW-1:0] fill_c;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] emit_cnt;
  logic [ZW-1:0] zrun_inc;
  logic          accept;
  logic          subst;
  logic          viol_pos;
  logic          b_wr;
  logic [IW-1:0] bidx;
  hdbn_pkg::sym_t new_sym;
  logic          emit;
  logic          final_sym;
  logic          ob_room;
  hdbn_pkg::out_item_t emit_item;
  hdbn_pkg::cell_ctrl_t ctrl [D];
  hdbn_pkg::sym_t upd [D];

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (pend_r == '0) && ob_room;
  assign cfg_ch.ready = 1'b1;

  // Order register; the configuration channel is always ready.
  assign order_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.zero_run_order : order_r;

  // Effective order, clamped to the supported range.
  always_comb begin
    order_raw = CW'(order_r);
    if (order_raw < CW'(hdbn_pkg::MIN_ORDER)) begin
      ord = CW'(hdbn_pkg::MIN_ORDER);
    end else if (order_raw > CW'(MAX_ORDER)) begin
      ord = CW'(MAX_ORDER);
    end else begin
      ord = order_raw;
    end
  end

  // Symbol decision for the incoming bit.
  always_comb begin
    zrun_inc = (zrun_r == {ZW{1'b1}}) ? zrun_r : zrun_r + ZW'(1);
    fill_c   = CW'(fill_r);
    fill_inc = fill_c + CW'(1);
    viol_pos = !lvp_r;
    subst    = !in_ch.data_bit && (CW'(zrun_inc) >= ord + CW'(1));
    b_wr     = subst && (lmp_r != viol_pos) && (fill_c >= ord);
    bidx     = IW'(fill_c - ord);
    if (in_ch.data_bit) begin
      new_sym = lmp_r ? hdbn_pkg::SYM_NEG : hdbn_pkg::SYM_POS;
    end else if (subst) begin
      new_sym = viol_pos ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
    end else begin
      new_sym = hdbn_pkg::SYM_ZERO;
    end
  end

  // Number of symbols released by the incoming item.
  always_comb begin
    if (in_ch.end_of_message) begin
      emit_cnt = fill_inc;
    end else if (fill_inc > ord) begin
      emit_cnt = fill_inc - ord;
    end else begin
      emit_cnt = '0;
    end
  end

  // Emission of the oldest symbol and the drain bookkeeping.
  always_comb begin
    if (accept) begin
      emit      = (emit_cnt != '0);
      final_sym = in_ch.end_of_message && (emit_cnt == CW'(1));
      pend_nxt  = (emit_cnt != '0) ? FW'(emit_cnt - CW'(1)) : '0;
      drain_nxt = in_ch.end_of_message;
    end else begin
      emit      = (pend_r != '0) && ob_room;
      final_sym = drain_r && (pend_r == FW'(1));
      pend_nxt  = emit ? pend_r - FW'(1) : pend_r;
      drain_nxt = (emit && (pend_r == FW'(1))) ? 1'b0 : drain_r;
    end
    fill_nxt = FW'(fill_c + CW'(accept) - CW'(emit));
  end

  // Polarity and zero-run state; an end-of-message item returns them to reset.
  always_comb begin
    lmp_nxt  = lmp_r;
    lvp_nxt  = lvp_r;
    zrun_nxt = zrun_r;
    if (accept) begin
      if (in_ch.end_of_message) begin
        lmp_nxt  = 1'b0;
        lvp_nxt  = 1'b0;
        zrun_nxt = '0;
      end else if (in_ch.data_bit) begin
        lmp_nxt  = !lmp_r;
        zrun_nxt = '0;
      end else if (subst) begin
        lmp_nxt  = b_wr ? viol_pos : lmp_r;
        lvp_nxt  = viol_pos;
        zrun_nxt = '0;
      end else begin
        zrun_nxt = zrun_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= hdbn_pkg::ORDER_RESET;
      fill_r  <= '0;
      pend_r  <= '0;
      drain_r <= 1'b0;
      zrun_r  <= '0;
      lmp_r   <= 1'b0;
      lvp_r   <= 1'b0;
    end else begin
      order_r <= order_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      drain_r <= drain_nxt;
      zrun_r  <= zrun_nxt;
      lmp_r   <= lmp_nxt;
      lvp_r   <= lvp_nxt;
    end
  end

  // Delay line: the new symbol lands at the fill position, a balancing pulse
  // goes back to the first zero of the run, and the head leaves on emission.
  for (genvar i = 0; i < D; i++) begin : g_cell
    hdbn_pkg::sym_t right;

    assign ctrl[i].wr_en  = accept && ((IW'(i) == fill_r[IW-1:0]) ||
                                       (b_wr && (IW'(i) == bidx)));
    assign ctrl[i].wr_sym = new_sym;
    assign ctrl[i].shift  = emit;

    if (i == D - 1) begin : g_last
      assign right = hdbn_pkg::SYM_ZERO;
    end else begin : g_mid
      assign right = upd[i+1];
    end

    hdbn_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[i]),
      .right_upd (right),
      .upd       (upd[i])
    );
  end

  // Result item from the head of the line.
  assign emit_item.pos_pulse    = (upd[0] == hdbn_pkg::SYM_POS);
  assign emit_item.neg_pulse    = (upd[0] == hdbn_pkg::SYM_NEG);
  assign emit_item.final_symbol = final_sym;

  hdbn_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_item (emit_item),
    .room      (ob_room),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== sim/tb_hdbn_line_encoder.sv =====
`timescale 1ns / 1ps

module tb_hdbn_line_encoder;

  localparam int LINE_DEPTH    = hdbn_pkg::MAX_ORDER_DEF + 1;
  localparam int SETTLE_CYCLES = hdbn_pkg::MAX_ORDER_DEF + 4;
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASE_ITEMS   = 26;

  // Tracks the encoder state and holds the symbols still owed on the result channel.
  class hdbn_symbol_predictor;
    logic [hdbn_pkg::ORDER_W-1:0] order_reg;
    hdbn_pkg::sym_t               line_sym [LINE_DEPTH];
    int unsigned                  fill;
    int unsigned                  zero_run;
    bit                           last_mark_pos;
    bit                           last_viol_pos;
    hdbn_pkg::out_item_t          pending_symbols [$];
    int unsigned                  mismatches;

    function new();
      order_reg  = hdbn_pkg::ORDER_RESET;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (line_sym[i]) line_sym[i] = hdbn_pkg::SYM_ZERO;
      fill          = 0;
      zero_run      = 0;
      last_mark_pos = 1'b0;
      last_viol_pos = 1'b0;
    endfunction

    // Out-of-range register values are clamped to the supported orders.
    function int unsigned active_order();
      int unsigned ord;
      ord = order_reg;
      if (ord < hdbn_pkg::MIN_ORDER) ord = hdbn_pkg::MIN_ORDER;
      if (ord > hdbn_pkg::MAX_ORDER_DEF) ord = hdbn_pkg::MAX_ORDER_DEF;
      return ord;
    endfunction

    function void release_oldest(bit last);
      hdbn_pkg::out_item_t sym_out;
      sym_out.pos_pulse    = (line_sym[0] == hdbn_pkg::SYM_POS);
      sym_out.neg_pulse    = (line_sym[0] == hdbn_pkg::SYM_NEG);
      sym_out.final_symbol = last;
      pending_symbols.push_back(sym_out);
      for (int i = 1; i < LINE_DEPTH; i++) line_sym[i-1] = line_sym[i];
      line_sym[LINE_DEPTH-1] = hdbn_pkg::SYM_ZERO;
      if (fill > 0) fill--;
    endfunction

    // Encodes one accepted item and queues every symbol it releases.
    function void take_bit(logic data_bit, logic end_of_message);
      int unsigned    ord;
      int unsigned    b_pos;
      hdbn_pkg::sym_t sym;
      bit             viol_pos;
      bit             can_balance;
      ord = active_order();
      if (fill >= LINE_DEPTH) fill = LINE_DEPTH - 1;
      if (data_bit) begin
        sym           = last_mark_pos ? hdbn_pkg::SYM_NEG : hdbn_pkg::SYM_POS;
        last_mark_pos = (sym == hdbn_pkg::SYM_POS);
        zero_run      = 0;
      end else begin
        if (zero_run < 7) zero_run++;
        if (zero_run >= ord + 1) begin
          // The run is long enough: a violation, with a balancing pulse when needed.
          viol_pos    = !last_viol_pos;
          can_balance = (fill + 1 >= ord + 1);
          b_pos       = can_balance ? fill - ord : 0;
          sym         = viol_pos ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
          if (last_mark_pos != viol_pos && can_balance && b_pos < LINE_DEPTH) begin
            line_sym[b_pos] = sym;
            last_mark_pos   = viol_pos;
          end
          last_viol_pos = viol_pos;
          zero_run      = 0;
        end else begin
          sym = hdbn_pkg::SYM_ZERO;
        end
      end
      line_sym[fill] = sym;
      fill++;
      if (end_of_message) begin
        while (fill > 0) release_oldest(fill == 1);
        clear_line();
      end else begin
        while (fill > ord) release_oldest(1'b0);
      end
    endfunction

    // Compares one accepted result item with the oldest expected symbol.
    function void check_symbol(hdbn_pkg::out_item_t got);
      hdbn_pkg::out_item_t want;
      if (pending_symbols.size() == 0) begin
        $error("unexpected symbol: pos=%0b neg=%0b final=%0b",
               got.pos_pulse, got.neg_pulse, got.final_symbol);
        mismatches++;
        return;
      end
      want = pending_symbols.pop_front();
      if (got.pos_pulse !== want.pos_pulse) begin
        $error("pos_pulse: expected %0b, actual %0b", want.pos_pulse, got.pos_pulse);
        mismatches++;
      end
      if (got.neg_pulse !== want.neg_pulse) begin
        $error("neg_pulse: expected %0b, actual %0b", want.neg_pulse, got.neg_pulse);
        mismatches++;
      end
      if (got.final_symbol !== want.final_symbol) begin
        $error("final_symbol: expected %0b, actual %0b",
               want.final_symbol, got.final_symbol);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned quiet_cycles;

  hdbn_symbol_predictor predictor = new();

  hdbn_in_if  in_ch ();
  hdbn_out_if out_ch ();
  hdbn_cfg_if cfg_ch ();

  hdbn_line_encoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random and checks every accepted result item.
  always @(posedge clk) begin
    hdbn_pkg::out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pos_pulse    = out_ch.pos_pulse;
      got.neg_pulse    = out_ch.neg_pulse;
      got.final_symbol = out_ch.final_symbol;
      predictor.check_symbol(got);
    end
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // The watchdog ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("hdbn_line_encoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one bit, idling first at random, and records it once it is taken.
  task automatic send_item(input logic data_bit, input logic end_of_message);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_bit       <= data_bit;
    in_ch.end_of_message <= end_of_message;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predictor.take_bit(data_bit, end_of_message);
  endtask

  // Sends a fixed pattern, oldest bit in the most significant place.
  task automatic send_bits(input logic [31:0] bits, input int len, input bit closes);
    for (int i = 0; i < len; i++) send_item(bits[len-1-i], closes && (i == len - 1));
  endtask

  // Holds the sender off until every owed symbol has arrived and the line is quiet.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (predictor.pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input logic [hdbn_pkg::ORDER_W-1:0] value);
    drain_results();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.zero_run_order <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid        <= 1'b0;
    predictor.order_reg = value;
  endtask

  // One message of random content, zero-heavy so that runs get substituted.
  task automatic send_random_message(input bit change_order, inout int sent);
    int unsigned len;
    int unsigned zero_pct;
    len      = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
    zero_pct = ($urandom_range(2) == 0) ? 50 : (($urandom_range(1) == 0) ? 75 : 92);
    for (int unsigned i = 0; i < len; i++) begin
      if (change_order && i == len / 2 && i > 0) begin
        write_order(hdbn_pkg::ORDER_W'($urandom_range(7)));
      end
      send_item($urandom_range(99) >= zero_pct, i == len - 1);
      sent++;
    end
  endtask

  initial begin
    logic [hdbn_pkg::ORDER_W-1:0] phase_order [8];
    int unsigned                  idle_mix [4];
    int unsigned                  stall_mix [4];
    int                           sent;
    phase_order = '{3'd2, 3'd4, 3'd7, 3'd1, 3'd3, 3'd6, 3'd5, 3'd0};
    idle_mix    = '{0, 47, 0, 18};
    stall_mix   = '{0, 0, 47, 18};
    sender_idle_pct       = 0;
    receiver_stall_pct    = 0;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.data_bit        <= 1'b0;
    in_ch.end_of_message  <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.zero_run_order <= hdbn_pkg::ORDER_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset order: first mark positive, violations with balancing pulses, drain.
    send_bits(32'b11000000001, 11, 1'b1);
    // A message of a single zero bit.
    send_bits(32'b0, 1, 1'b1);
    // Order lowered mid-message releases several symbols at once.
    write_order(3'd4);
    send_bits(32'b0000, 4, 1'b0);
    write_order(3'd2);
    send_bits(32'b010, 3, 1'b1);
    // A register value below the smallest order acts as the smallest order.
    write_order(3'd0);
    send_bits(32'b10001, 5, 1'b1);

    // Random phases over every mix of sender idling and receiver stalling.
    for (int phase = 0; phase < 8; phase++) begin
      write_order(phase_order[phase]);
      sender_idle_pct    = idle_mix[phase % 4];
      receiver_stall_pct = stall_mix[phase % 4];
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_message(phase == 5 || phase == 6, sent);
    end

    drain_results();
    if (predictor.mismatches == 0) begin
      $display("hdbn_line_encoder: match");
    end else begin
      $display("hdbn_line_encoder: mismatch");
    end
    $finish;
  end

endmodule
